/* src/rotation_matrix_to_quaternion_defines.svh */
// assertion macros for the rotation matrix to quaternion converter
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// same-cycle implication, off while reset is high
`define RMQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define RMQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/rmq_pkg.sv */
// shared constants, types, step functions and lane saturation of the quaternion converter
package rmq_pkg;

   localparam int DATA_W       = 32;
   localparam int FRAC_BITS    = 30;
   localparam int NUM_W        = DATA_W + 1;
   localparam int SUM_W        = DATA_W + 2;
   localparam int ARG_W        = DATA_W + 3;
   localparam int RAD_W        = ((DATA_W + FRAC_BITS + 2) / 2) * 2;
   localparam int ROOT_W       = RAD_W / 2;
   localparam int REM_W        = ROOT_W + 3;
   localparam int DEN_W        = ROOT_W + 1;
   localparam int OV_SHIFT     = DATA_W - FRAC_BITS;
   localparam int CMP_W        = DEN_W + DATA_W;
   localparam int SQ_PER_STAGE = 4;
   localparam int SQ_STAGES    = (ROOT_W + SQ_PER_STAGE - 1) / SQ_PER_STAGE;
   localparam int DV_PER_STAGE = 4;
   localparam int DV_STAGES    = (DATA_W + DV_PER_STAGE - 1) / DV_PER_STAGE;
   localparam int LANES        = 3;
   localparam int MAT_W        = 9 * DATA_W;
   localparam int IN_W         = ((MAT_W + 7) / 8) * 8;
   localparam int QUAT_W       = 4 * DATA_W;
   localparam int OUT_W        = ((QUAT_W + 7) / 8) * 8;
   localparam int USER_W       = 3;

   localparam logic signed [ARG_W-1:0] ONE_ARG =
      {{(ARG_W - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

   typedef enum logic [1:0] {BR_TRACE, BR_M00, BR_M11, BR_M22} br_type;

   typedef logic signed [DATA_W-1:0] elem_type;

   // m00 sits in the lowest bits
   typedef struct packed {
      elem_type m22;
      elem_type m21;
      elem_type m20;
      elem_type m12;
      elem_type m11;
      elem_type m10;
      elem_type m02;
      elem_type m01;
      elem_type m00;
   } mat_type;

   // numerators in w, x, y, z order with the quarter component left out
   typedef struct packed {
      br_type                       br;
      logic                         bad;
      logic [LANES-1:0][NUM_W-1:0]  num;
   } side_type;

   typedef struct packed {
      side_type          side;
      logic [RAD_W-1:0]  rad;
   } front_type;

   typedef struct packed {
      side_type           side;
      logic [ROOT_W-1:0]  root;
   } root_type;

   typedef struct packed {
      logic [REM_W-1:0]   rem;
      logic [ROOT_W-1:0]  root;
      logic [RAD_W-1:0]   rad;
   } sq_state_type;

   typedef struct packed {
      logic [DEN_W-1:0]   rem;
      logic [DATA_W-1:0]  quo;
      logic [DATA_W-1:0]  bits;
   } dv_state_type;

   typedef struct packed {
      logic          neg;
      logic          ovf;
      dv_state_type  st;
   } lane_type;

   typedef struct packed {
      br_type                   br;
      logic                     degen;
      logic [ROOT_W-1:0]        root;
      logic [DEN_W-1:0]         den;
      lane_type [LANES-1:0]     lane;
   } quo_type;

   // one digit of the restoring square root
   function automatic sq_state_type sq_step(input sq_state_type cur);
      sq_state_type      nxt;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      rem_sh   = {cur.rem[REM_W-3:0], cur.rad[RAD_W-1 -: 2]};
      trial    = REM_W'({cur.root, 2'b01});
      nxt.rad  = cur.rad << 2;
      if (rem_sh >= trial) begin
         nxt.rem  = rem_sh - trial;
         nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
      end else begin
         nxt.rem  = rem_sh;
         nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

   // one quotient bit of the restoring divider
   function automatic dv_state_type dv_step(input dv_state_type cur,
                                            input logic [DEN_W-1:0] den);
      dv_state_type    nxt;
      logic [DEN_W:0]  t;
      logic [DEN_W:0]  d;
      t        = {cur.rem, cur.bits[DATA_W-1]};
      d        = {1'b0, den};
      nxt.bits = cur.bits << 1;
      if (t >= d) begin
         nxt.rem = DEN_W'(t - d);
         nxt.quo = {cur.quo[DATA_W-2:0], 1'b1};
      end else begin
         nxt.rem = t[DEN_W-1:0];
         nxt.quo = {cur.quo[DATA_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

   // signed, saturated value of one quotient lane
   function automatic logic [DATA_W-1:0] sat_lane(input lane_type ln);
      logic [DATA_W-1:0] v;
      if (ln.ovf) begin
         v = ln.neg ? SAT_MIN : SAT_MAX;
      end else if (!ln.neg) begin
         v = ln.st.quo[DATA_W-1] ? SAT_MAX : ln.st.quo;
      end else if (ln.st.quo > SAT_MIN) begin
         v = SAT_MIN;
      end else begin
         v = ~ln.st.quo + 1'b1;
      end
      return v;
   endfunction

endpackage

/* src/rmq_front.sv */
// front end: trace, branch pick, root argument and numerators
module rmq_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  rmq_pkg::mat_type    in_mat,
   output logic                out_valid,
   output rmq_pkg::front_type  out_data
);
   import rmq_pkg::*;

   logic                     vld0_ff;
   logic                     vld1_ff;
   mat_type                  mat_ff;
   br_type                   br_ff;
   br_type                   br_in;
   logic signed [SUM_W-1:0]  tr_ff;
   logic signed [SUM_W-1:0]  tr_in;
   front_type                data_ff;
   front_type                data_in;

   logic signed [ARG_W-1:0]  a_x, e_x, k_x, arg;
   logic signed [NUM_W-1:0]  b_x, c_x, d_x, f_x, g_x, h_x;
   logic signed [NUM_W-1:0]  hf, cg, db, bd, cgs, fh;

   always_comb begin
      tr_in = SUM_W'(in_mat.m00) + SUM_W'(in_mat.m11) + SUM_W'(in_mat.m22);
      if (tr_in > 0) begin
         br_in = BR_TRACE;
      end else if (in_mat.m00 > in_mat.m11 && in_mat.m00 > in_mat.m22) begin
         br_in = BR_M00;
      end else if (in_mat.m11 > in_mat.m22) begin
         br_in = BR_M11;
      end else begin
         br_in = BR_M22;
      end
   end

   always_comb begin
      a_x = ARG_W'(mat_ff.m00);
      e_x = ARG_W'(mat_ff.m11);
      k_x = ARG_W'(mat_ff.m22);
      b_x = NUM_W'(mat_ff.m01);
      c_x = NUM_W'(mat_ff.m02);
      d_x = NUM_W'(mat_ff.m10);
      f_x = NUM_W'(mat_ff.m12);
      g_x = NUM_W'(mat_ff.m20);
      h_x = NUM_W'(mat_ff.m21);
      hf  = h_x - f_x;
      cg  = c_x - g_x;
      db  = d_x - b_x;
      bd  = b_x + d_x;
      cgs = c_x + g_x;
      fh  = f_x + h_x;
      data_in.side.br = br_ff;
      case (br_ff)
         BR_TRACE: begin
            arg = ARG_W'(tr_ff) + ONE_ARG;
            data_in.side.num[0] = hf;
            data_in.side.num[1] = cg;
            data_in.side.num[2] = db;
         end
         BR_M00: begin
            arg = ONE_ARG + a_x - e_x - k_x;
            data_in.side.num[0] = hf;
            data_in.side.num[1] = bd;
            data_in.side.num[2] = cgs;
         end
         BR_M11: begin
            arg = ONE_ARG + e_x - a_x - k_x;
            data_in.side.num[0] = cg;
            data_in.side.num[1] = bd;
            data_in.side.num[2] = fh;
         end
         default: begin
            arg = ONE_ARG + k_x - a_x - e_x;
            data_in.side.num[0] = db;
            data_in.side.num[1] = cgs;
            data_in.side.num[2] = fh;
         end
      endcase
      data_in.side.bad = (arg <= 0);
      // argument scaled up by the fraction bits so the root keeps the format
      data_in.rad = data_in.side.bad ? '0 :
                    (RAD_W'(arg[DATA_W:0]) << FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
      end else if (adv) begin
         vld0_ff <= in_valid;
         vld1_ff <= vld0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mat_ff  <= in_mat;
         br_ff   <= br_in;
         tr_ff   <= tr_in;
         data_ff <= data_in;
      end
   end

   assign out_valid = vld1_ff;
   assign out_data  = data_ff;

endmodule

/* src/rmq_sqrt.sv */
// pipelined integer square root, SQ_PER_STAGE digits per stage
module rmq_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  rmq_pkg::front_type  in_data,
   output logic                out_valid,
   output rmq_pkg::root_type   out_data
);
   import rmq_pkg::*;

   logic          vld_ff [SQ_STAGES];
   logic          vld_src [SQ_STAGES];
   sq_state_type  st_ff [SQ_STAGES];
   sq_state_type  st_in [SQ_STAGES];
   sq_state_type  st_src [SQ_STAGES];
   side_type      sd_ff [SQ_STAGES];
   side_type      sd_src [SQ_STAGES];

   for (genvar i = 0; i < SQ_STAGES; i++) begin : g_stage
      if (i == 0) begin : g_first
         assign vld_src[i]     = in_valid;
         assign sd_src[i]      = in_data.side;
         assign st_src[i].rem  = '0;
         assign st_src[i].root = '0;
         assign st_src[i].rad  = in_data.rad;
      end else begin : g_next
         assign vld_src[i] = vld_ff[i-1];
         assign sd_src[i]  = sd_ff[i-1];
         assign st_src[i]  = st_ff[i-1];
      end

      always_comb begin
         st_in[i] = st_src[i];
         for (int j = 0; j < SQ_PER_STAGE; j++) begin
            if (i * SQ_PER_STAGE + j < ROOT_W) begin
               st_in[i] = sq_step(st_in[i]);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_src[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[i] <= st_in[i];
            sd_ff[i] <= sd_src[i];
         end
      end
   end

   assign out_valid     = vld_ff[SQ_STAGES-1];
   assign out_data.side = sd_ff[SQ_STAGES-1];
   assign out_data.root = st_ff[SQ_STAGES-1].root;

endmodule

/* src/rmq_div.sv */
// three pipelined restoring dividers sharing one divisor
module rmq_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  rmq_pkg::root_type  in_data,
   output logic               out_valid,
   output rmq_pkg::quo_type   out_data
);
   import rmq_pkg::*;

   logic                     prep_vld_ff;
   quo_type                  prep_ff;
   quo_type                  prep_in;
   logic [NUM_W-1:0]         mag;
   logic                     vld_ff [DV_STAGES];
   logic                     vld_src [DV_STAGES];
   quo_type                  q_ff [DV_STAGES];
   quo_type                  q_in [DV_STAGES];
   quo_type                  q_src [DV_STAGES];

   // sign split, overflow check and first partial remainder
   always_comb begin
      prep_in.br    = in_data.side.br;
      prep_in.root  = in_data.root;
      prep_in.den   = {in_data.root, 1'b0};
      prep_in.degen = in_data.side.bad || (in_data.root == '0);
      mag           = '0;
      for (int l = 0; l < LANES; l++) begin
         prep_in.lane[l].neg = in_data.side.num[l][NUM_W-1];
         mag = prep_in.lane[l].neg ? (~in_data.side.num[l] + 1'b1) :
                                     in_data.side.num[l];
         prep_in.lane[l].ovf = CMP_W'(mag) >= (CMP_W'(prep_in.den) << OV_SHIFT);
         prep_in.lane[l].st.rem  = prep_in.lane[l].ovf ? '0 :
                                   DEN_W'(mag >> OV_SHIFT);
         prep_in.lane[l].st.quo  = '0;
         prep_in.lane[l].st.bits = DATA_W'({mag, {FRAC_BITS{1'b0}}});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_vld_ff <= 1'b0;
      end else if (adv) begin
         prep_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prep_ff <= prep_in;
      end
   end

   for (genvar i = 0; i < DV_STAGES; i++) begin : g_stage
      if (i == 0) begin : g_first
         assign vld_src[i] = prep_vld_ff;
         assign q_src[i]   = prep_ff;
      end else begin : g_next
         assign vld_src[i] = vld_ff[i-1];
         assign q_src[i]   = q_ff[i-1];
      end

      always_comb begin
         q_in[i] = q_src[i];
         for (int l = 0; l < LANES; l++) begin
            for (int j = 0; j < DV_PER_STAGE; j++) begin
               if (i * DV_PER_STAGE + j < DATA_W) begin
                  q_in[i].lane[l].st = dv_step(q_in[i].lane[l].st, q_src[i].den);
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_src[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff[i] <= q_in[i];
         end
      end
   end

   assign out_valid = vld_ff[DV_STAGES-1];
   assign out_data  = q_ff[DV_STAGES-1];

endmodule

/* src/rotation_matrix_to_quaternion.sv */
// top level: rotation matrix to unit quaternion, trace and largest-diagonal method
// 20 register stages (2 front, 8 root, 9 divide, 1 out) lie between req_tdata and rsp_tdata
// throughput one matrix per cycle while no held result stalls the pipeline;
// the root and divider pipelines fix the depth
// a stalled result freezes every stage, so nothing is lost or repeated
// synchronous active-high reset clears all valid bits; payload is not reset
`include "rotation_matrix_to_quaternion_defines.svh"
module rotation_matrix_to_quaternion (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
   input  logic [rmq_pkg::IN_W-1:0]      req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // quat_w, quat_x, quat_y, quat_z from bit 0 up
   output logic [rmq_pkg::OUT_W-1:0]     rsp_tdata,
   // branch_taken [1:0], degenerate [2]
   output logic [rmq_pkg::USER_W-1:0]    rsp_tuser
);
   import rmq_pkg::*;

   // global advance: every stage moves unless a finished result is held
   logic                 adv;
   mat_type              in_mat;

   logic                 front_valid;
   front_type            front_data;
   logic                 root_valid;
   root_type             root_data;
   logic                 div_valid;
   quo_type              div_data;

   // output register
   logic                 rsp_valid_ff;
   logic [OUT_W-1:0]     rsp_data_ff;
   logic [OUT_W-1:0]     rsp_data_in;
   logic [USER_W-1:0]    rsp_user_ff;
   logic [USER_W-1:0]    rsp_user_in;

   logic [DATA_W-1:0]    quarter;
   logic [DATA_W-1:0]    sv0, sv1, sv2;
   logic [DATA_W-1:0]    qw, qx, qy, qz;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign in_mat     = mat_type'(req_tdata[MAT_W-1:0]);

   // trace, branch and root argument
   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_mat    (in_mat),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   // r = floor(sqrt(arg * 2^frac))
   rmq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (root_valid),
      .out_data  (root_data)
   );

   // three numerators over s = 2r
   rmq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (root_valid),
      .in_data   (root_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   // saturate the quotients and slot the quarter component in by branch
   always_comb begin
      quarter = DATA_W'(div_data.root >> 1);
      sv0     = sat_lane(div_data.lane[0]);
      sv1     = sat_lane(div_data.lane[1]);
      sv2     = sat_lane(div_data.lane[2]);
      case (div_data.br)
         BR_TRACE: begin
            qw = quarter; qx = sv0;     qy = sv1;     qz = sv2;
         end
         BR_M00: begin
            qw = sv0;     qx = quarter; qy = sv1;     qz = sv2;
         end
         BR_M11: begin
            qw = sv0;     qx = sv1;     qy = quarter; qz = sv2;
         end
         default: begin
            qw = sv0;     qx = sv1;     qy = sv2;     qz = quarter;
         end
      endcase
      // degenerate root argument forces a zero quaternion
      if (div_data.degen) begin
         rsp_data_in = '0;
      end else begin
         rsp_data_in = OUT_W'({qz, qy, qx, qw});
      end
      rsp_user_in = {div_data.degen, div_data.br};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // degenerate results carry an all-zero quaternion
   `RMQ_ASSERT_NOW(a_degen_zero, clock, reset, rsp_tvalid && rsp_tuser[2], rsp_tdata == '0, "degenerate result with nonzero quaternion")
   // trace branch: w is s/4 and never negative
   `RMQ_ASSERT_NOW(a_trace_w_pos, clock, reset, rsp_tvalid && (rsp_tuser[1:0] == BR_TRACE) && !rsp_tuser[2], !rsp_tdata[DATA_W-1], "trace branch gave negative w")
   // a finished divider item reaches the output register on advance
   `RMQ_ASSERT_NEXT(a_div_to_out, clock, reset, div_valid && adv, rsp_tvalid, "divider result dropped before output")

endmodule
